### rtl/scc_pkg.sv
// Shared types and helpers for the sphere and cylinder collision block.
`default_nettype none
package scc_pkg;

    localparam int MAG_W   = 19;
    localparam int RS_W    = 17;
    localparam int SQ_W    = 38;
    localparam int RT_W    = 36;
    localparam int Q_W     = 18;
    localparam int SQRT_N  = 17;
    localparam int DIV_N   = 18;
    localparam int SQRT_0  = 3;
    localparam int MUL_ST  = SQRT_0 + SQRT_N;
    localparam int NUM_ST  = MUL_ST + 1;
    localparam int DIV_0   = NUM_ST + 1;
    localparam int N_STG   = DIV_0 + DIV_N;
    localparam logic [33:0] DIFF_LIM = 34'd262144;

    typedef struct packed {
        logic [2:0][MAG_W-1:0] mag;
        logic [2:0]            sgn;
        logic [RS_W-1:0]       rs;
        logic                  neg;
        logic                  zfail;
    } t_ent;

    typedef struct packed {
        logic [2:0][MAG_W-1:0] mag;
        logic [2:0]            sgn;
        logic [RS_W-1:0]       rs;
        logic                  neg;
        logic                  zfail;
        logic [2:0][SQ_W-1:0]  sq;
        logic [SQ_W-1:0]       dsum;
        logic [33:0]           rs2;
        logic                  hit;
        logic                  zero;
        logic [RT_W-1:0]       n;
        logic [RT_W-1:0]       res;
        logic [2:0][36:0]      am;
        logic [SQ_W-1:0]       den;
        logic [2:0][SQ_W-1:0]  num;
        logic [2:0][Q_W-1:0]   q;
    } t_bk;

    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic             sgn;
    } t_cmag;

    function automatic t_cmag clamp_mag(input logic signed [33:0] d);
        t_cmag r;
        logic [33:0] a;
        a = d[33] ? 34'(-d) : 34'(d);
        r.sgn = d[33];
        r.mag = (a > DIFF_LIM) ? MAG_W'(DIFF_LIM) : a[MAG_W-1:0];
        return r;
    endfunction

endpackage
`default_nettype wire

### rtl/scc_fifo.sv
// Small first-in first-out queue of packed items.
`default_nettype none
module scc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_rd,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_full,
    output logic                  o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [AW:0]      r_cnt;
    logic             w_wr, w_rd;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_wr    = i_wr && !o_full;
    assign w_rd    = i_rd && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(w_wr) - (AW+1)'(w_rd);
        end
    end
endmodule
`default_nettype wire

### rtl/scc_front.sv
// Front part: orders the pair, picks the case and forms clamped differences.
`default_nettype none
module scc_front #(
    parameter int COORD_WIDTH = 24
) (
    input  wire logic                   i_a_is_cylinder,
    input  wire logic                   i_b_is_cylinder,
    input  wire logic [COORD_WIDTH-1:0] i_a_pos_x,
    input  wire logic [COORD_WIDTH-1:0] i_a_pos_y,
    input  wire logic [COORD_WIDTH-1:0] i_a_pos_z,
    input  wire logic [COORD_WIDTH-1:0] i_b_pos_x,
    input  wire logic [COORD_WIDTH-1:0] i_b_pos_y,
    input  wire logic [COORD_WIDTH-1:0] i_b_pos_z,
    input  wire logic [15:0]            i_a_radius,
    input  wire logic [15:0]            i_a_height,
    input  wire logic [15:0]            i_b_radius,
    input  wire logic [15:0]            i_b_height,
    output scc_pkg::t_ent               o_ent
);
    localparam int XW = 34 - COORD_WIDTH;

    logic signed [33:0] ax, ay, az, bx, by, bz;
    logic signed [33:0] px, py, pz, qx, qy, qz, qh, top, dz;
    logic               swap, one_cyl, in_span;
    scc_pkg::t_cmag     cx, cy, cz;

    always_comb begin
        ax = {{XW{i_a_pos_x[COORD_WIDTH-1]}}, i_a_pos_x};
        ay = {{XW{i_a_pos_y[COORD_WIDTH-1]}}, i_a_pos_y};
        az = {{XW{i_a_pos_z[COORD_WIDTH-1]}}, i_a_pos_z};
        bx = {{XW{i_b_pos_x[COORD_WIDTH-1]}}, i_b_pos_x};
        by = {{XW{i_b_pos_y[COORD_WIDTH-1]}}, i_b_pos_y};
        bz = {{XW{i_b_pos_z[COORD_WIDTH-1]}}, i_b_pos_z};
        swap    = i_a_is_cylinder && !i_b_is_cylinder;
        one_cyl = i_a_is_cylinder ^ i_b_is_cylinder;
        px = swap ? bx : ax;
        py = swap ? by : ay;
        pz = swap ? bz : az;
        qx = swap ? ax : bx;
        qy = swap ? ay : by;
        qz = swap ? az : bz;
        qh = {18'b0, (swap ? i_a_height : i_b_height)};
        top     = qz + qh;
        in_span = (pz >= qz) && (pz <= top);
        if (!i_a_is_cylinder && !i_b_is_cylinder) begin
            dz = qz - pz;
        end else if (one_cyl && !in_span) begin
            dz = ((pz < qz) ? qz : top) - pz;
        end else begin
            dz = '0;
        end
        cx = scc_pkg::clamp_mag(qx - px);
        cy = scc_pkg::clamp_mag(qy - py);
        cz = scc_pkg::clamp_mag(dz);
        o_ent.mag   = {cz.mag, cy.mag, cx.mag};
        o_ent.sgn   = {cz.sgn, cy.sgn, cx.sgn};
        o_ent.rs    = {1'b0, i_a_radius} + {1'b0, i_b_radius};
        o_ent.neg   = swap;
        o_ent.zfail = i_a_is_cylinder && i_b_is_cylinder &&
                      !((az <= bz + $signed({18'b0, i_b_height})) &&
                        (bz <= az + $signed({18'b0, i_a_height})));
    end
endmodule
`default_nettype wire

### rtl/scc_back.sv
// Back part: squares, compare, square root, scaling division and saturation.
`default_nettype none
module scc_back #(
    parameter int COORD_WIDTH = 24
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_en,
    input  wire logic                   i_valid,
    input  scc_pkg::t_ent               i_ent,
    output logic                        o_valid,
    output logic                        o_hit,
    output logic [COORD_WIDTH-1:0]      o_push_x,
    output logic [COORD_WIDTH-1:0]      o_push_y,
    output logic [COORD_WIDTH-1:0]      o_push_z
);
    localparam int NS = scc_pkg::N_STG;
    localparam logic signed [32:0] HI = (33'sd1 <<< (COORD_WIDTH-1)) - 33'sd1;
    localparam logic signed [32:0] LO = -HI - 33'sd1;

    scc_pkg::t_bk r_s [NS];
    scc_pkg::t_bk n_s [NS];
    logic [NS-1:0] r_v;
    logic [NS-1:0] n_v;
    logic [COORD_WIDTH-1:0] w_p [3];

    always_comb begin
        logic [scc_pkg::RT_W-1:0] bt;
        logic [17:0]              m;
        logic [scc_pkg::SQ_W-1:0] ds;
        logic signed [32:0]       v;
        bt = '0;
        m  = '0;
        ds = '0;
        v  = '0;
        n_v = {r_v[NS-2:0], i_valid};
        for (int k = 0; k < NS; k++) begin
            if (k == 0) begin
                n_s[k]       = '0;
                n_s[k].mag   = i_ent.mag;
                n_s[k].sgn   = i_ent.sgn;
                n_s[k].rs    = i_ent.rs;
                n_s[k].neg   = i_ent.neg;
                n_s[k].zfail = i_ent.zfail;
                for (int j = 0; j < 3; j++) begin
                    n_s[k].sq[j] = i_ent.mag[j] * i_ent.mag[j];
                end
            end else begin
                n_s[k] = r_s[k-1];
                if (k == 1) begin
                    n_s[k].dsum = r_s[k-1].sq[0] + r_s[k-1].sq[1] + r_s[k-1].sq[2];
                    n_s[k].rs2  = r_s[k-1].rs * r_s[k-1].rs;
                end else if (k == 2) begin
                    n_s[k].hit  = (r_s[k-1].dsum < {4'b0, r_s[k-1].rs2}) && !r_s[k-1].zfail;
                    n_s[k].zero = (r_s[k-1].dsum == '0);
                    n_s[k].n    = {2'b0, r_s[k-1].dsum[33:0]};
                    n_s[k].res  = '0;
                end else if (k < scc_pkg::MUL_ST) begin
                    bt = scc_pkg::RT_W'(1) << (2 * (scc_pkg::SQRT_N - 1 - (k - scc_pkg::SQRT_0)));
                    if (r_s[k-1].n >= r_s[k-1].res + bt) begin
                        n_s[k].n   = r_s[k-1].n - (r_s[k-1].res + bt);
                        n_s[k].res = (r_s[k-1].res >> 1) + bt;
                    end else begin
                        n_s[k].res = r_s[k-1].res >> 1;
                    end
                end else if (k == scc_pkg::MUL_ST) begin
                    m = {1'b0, r_s[k-1].rs} - r_s[k-1].res[17:0];
                    for (int j = 0; j < 3; j++) begin
                        n_s[k].am[j] = r_s[k-1].mag[j] * m;
                    end
                end else if (k == scc_pkg::NUM_ST) begin
                    n_s[k].den = scc_pkg::SQ_W'({r_s[k-1].res[17:0], 1'b0});
                    for (int j = 0; j < 3; j++) begin
                        n_s[k].num[j] = {r_s[k-1].am[j], 1'b0} +
                                        scc_pkg::SQ_W'(r_s[k-1].res[17:0]);
                        n_s[k].q[j]   = '0;
                    end
                end else begin
                    ds = r_s[k-1].den << (scc_pkg::DIV_N - 1 - (k - scc_pkg::DIV_0));
                    for (int j = 0; j < 3; j++) begin
                        if (r_s[k-1].num[j] >= ds) begin
                            n_s[k].num[j] = r_s[k-1].num[j] - ds;
                            n_s[k].q[j][scc_pkg::DIV_N - 1 - (k - scc_pkg::DIV_0)] = 1'b1;
                        end
                    end
                end
            end
        end
        for (int j = 0; j < 3; j++) begin
            v = {15'b0, r_s[NS-1].q[j]};
            if (r_s[NS-1].sgn[j] ^ r_s[NS-1].neg) begin
                v = -v;
            end
            if (!r_s[NS-1].hit || r_s[NS-1].zero) begin
                v = '0;
            end
            if (v > HI) begin
                v = HI;
            end else if (v < LO) begin
                v = LO;
            end
            w_p[j] = v[COORD_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NS; k++) begin
                r_s[k] <= n_s[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= n_v;
        end
    end

    assign o_valid  = r_v[NS-1];
    assign o_hit    = r_s[NS-1].hit;
    assign o_push_x = w_p[0];
    assign o_push_y = w_p[1];
    assign o_push_z = w_p[2];
endmodule
`default_nettype wire

### rtl/sphere_cylinder_collision_top.sv
// Throughput: one item per cycle while the result queue is not full.
// The 17-step root and 18-step division are fully pipelined, one back stage per step.
// The back pipeline holds as a whole while the result queue is full.
// Reset: synchronous active low; clears queue pointers, queue counts and stage valid bits only.
// Top level of the sphere and upright cylinder collision block.
`default_nettype none
module sphere_cylinder_collision_top #(
    parameter int COORD_WIDTH = 24
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   push,
    output logic                        full,
    input  wire logic                   i_a_is_cylinder,
    input  wire logic                   i_b_is_cylinder,
    input  wire logic [COORD_WIDTH-1:0] i_a_pos_x,
    input  wire logic [COORD_WIDTH-1:0] i_a_pos_y,
    input  wire logic [COORD_WIDTH-1:0] i_a_pos_z,
    input  wire logic [COORD_WIDTH-1:0] i_b_pos_x,
    input  wire logic [COORD_WIDTH-1:0] i_b_pos_y,
    input  wire logic [COORD_WIDTH-1:0] i_b_pos_z,
    input  wire logic [15:0]            i_a_radius,
    input  wire logic [15:0]            i_a_height,
    input  wire logic [15:0]            i_b_radius,
    input  wire logic [15:0]            i_b_height,
    output logic                        empty,
    input  wire logic                   pop,
    output logic                        o_hit,
    output logic [COORD_WIDTH-1:0]      o_push_x,
    output logic [COORD_WIDTH-1:0]      o_push_y,
    output logic [COORD_WIDTH-1:0]      o_push_z
);
    localparam int EW = $bits(scc_pkg::t_ent);
    localparam int RW = 1 + 3 * COORD_WIDTH;

    scc_pkg::t_ent          w_ent, w_qent;
    logic [EW-1:0]          w_qdata;
    logic                   w_mid_empty, w_mid_pop, w_en, w_bvalid, w_bhit, w_ofull;
    logic [COORD_WIDTH-1:0] w_bx, w_by, w_bz;
    logic [RW-1:0]          w_odata;

    scc_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .i_a_is_cylinder (i_a_is_cylinder),
        .i_b_is_cylinder (i_b_is_cylinder),
        .i_a_pos_x       (i_a_pos_x),
        .i_a_pos_y       (i_a_pos_y),
        .i_a_pos_z       (i_a_pos_z),
        .i_b_pos_x       (i_b_pos_x),
        .i_b_pos_y       (i_b_pos_y),
        .i_b_pos_z       (i_b_pos_z),
        .i_a_radius      (i_a_radius),
        .i_a_height      (i_a_height),
        .i_b_radius      (i_b_radius),
        .i_b_height      (i_b_height),
        .o_ent           (w_ent)
    );

    scc_fifo #(.WIDTH(EW), .DEPTH(4)) u_mid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (push),
        .i_data  (w_ent),
        .i_rd    (w_mid_pop),
        .o_data  (w_qdata),
        .o_full  (full),
        .o_empty (w_mid_empty)
    );

    assign w_qent    = scc_pkg::t_ent'(w_qdata);
    assign w_en      = !w_ofull;
    assign w_mid_pop = w_en && !w_mid_empty;

    scc_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (!w_mid_empty),
        .i_ent    (w_qent),
        .o_valid  (w_bvalid),
        .o_hit    (w_bhit),
        .o_push_x (w_bx),
        .o_push_y (w_by),
        .o_push_z (w_bz)
    );

    scc_fifo #(.WIDTH(RW), .DEPTH(2)) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_bvalid && w_en),
        .i_data  ({w_bhit, w_bx, w_by, w_bz}),
        .i_rd    (pop),
        .o_data  (w_odata),
        .o_full  (w_ofull),
        .o_empty (empty)
    );

    assign o_hit    = w_odata[RW-1];
    assign o_push_x = w_odata[3*COORD_WIDTH-1:2*COORD_WIDTH];
    assign o_push_y = w_odata[2*COORD_WIDTH-1:COORD_WIDTH];
    assign o_push_z = w_odata[COORD_WIDTH-1:0];

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_hit) |-> (o_push_x == '0 && o_push_y == '0 && o_push_z == '0))
        else $error("miss carries a nonzero push");

    a_mid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full) |=> !w_mid_empty)
        else $error("accepted item missing from queue");

    a_stall_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ofull |-> !w_mid_pop)
        else $error("queue drained while back part stalled");
endmodule
`default_nettype wire
